// ----- rtl/core/assert_macros.svh -----
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after its condition
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// ----- rtl/core/i2csw_pkg.sv -----
package i2csw_pkg;

	localparam int ADDR_W = 7;
	localparam int BYTE_W = 8;
	localparam int CNT_W = 4;
	localparam logic [CNT_W-1:0] BYTE_BITS = 4'd8;
	// number of data bytes taken after an acknowledged write address
	localparam logic [1:0] DATA_BYTES = 2'd2;

	typedef enum logic [6:0] {
		PH_IDLE     = 7'b0000001,
		PH_ADDR     = 7'b0000010,
		PH_ADDR_END = 7'b0000100,
		PH_ADDR_ACK = 7'b0001000,
		PH_DATA     = 7'b0010000,
		PH_DATA_END = 7'b0100000,
		PH_DATA_ACK = 7'b1000000
	} phase_t;

	typedef struct packed {
		logic scl;
		logic sda;
	} sample_t;

	typedef struct packed {
		logic              sda_pull_low;
		logic              byte_valid;
		logic [BYTE_W-1:0] byte_value;
		logic              byte_number;
	} result_t;

endpackage

// ----- rtl/core/i2csw_in_stage.sv -----
module i2csw_in_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  i2csw_pkg::sample_t  sample,
	input  logic                advance,
	output logic                valid_s1,
	output i2csw_pkg::sample_t  sample_s1
);

	logic in_fire;

	assign in_ready = !valid_s1 || advance;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			sample_s1 <= sample;
		end
	end

endmodule

// ----- rtl/core/i2csw_fsm.sv -----
`include "assert_macros.svh"

module i2csw_fsm (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic [i2csw_pkg::ADDR_W-1:0]        cfg_addr,
	input  logic                                fire,
	input  i2csw_pkg::sample_t                  sample_s1,
	output i2csw_pkg::result_t                  result
);

	i2csw_pkg::phase_t                  phase_q, phase_d;
	logic [i2csw_pkg::CNT_W-1:0]        bit_count_q, bit_count_d, cnt_inc;
	logic [i2csw_pkg::BYTE_W-1:0]       shift_q, shift_d, shifted;
	logic [i2csw_pkg::ADDR_W-1:0]       own_address_q;
	logic                               prev_scl_q, prev_sda_q;
	logic                               bytes_done_q, bytes_done_d;
	logic                               ack_q, ack_d;
	logic                               rise, fall;

	assign rise    = !prev_scl_q && sample_s1.scl;
	assign fall    = prev_scl_q && !sample_s1.scl;
	assign shifted = {shift_q[i2csw_pkg::BYTE_W-2:0], sample_s1.sda};
	assign cnt_inc = bit_count_q + 4'd1;

	always_comb begin
		phase_d             = phase_q;
		bit_count_d         = bit_count_q;
		shift_d             = shift_q;
		bytes_done_d        = bytes_done_q;
		ack_d               = ack_q;
		result.byte_valid   = 1'b0;
		result.byte_value   = '0;
		result.byte_number  = 1'b0;
		case (phase_q)
			i2csw_pkg::PH_ADDR, i2csw_pkg::PH_DATA: begin
				if (rise) begin
					shift_d     = shifted;
					bit_count_d = cnt_inc;
					if (cnt_inc >= i2csw_pkg::BYTE_BITS) begin
						if (phase_q == i2csw_pkg::PH_ADDR) begin
							// upper seven bits are the address, bit 0 is read/write
							if (shifted[i2csw_pkg::BYTE_W-1:1] == own_address_q) begin
								phase_d = i2csw_pkg::PH_ADDR_END;
							end else begin
								phase_d = i2csw_pkg::PH_IDLE;
							end
						end else begin
							result.byte_valid  = 1'b1;
							result.byte_value  = shifted;
							result.byte_number = bytes_done_q;
							phase_d            = i2csw_pkg::PH_DATA_END;
						end
					end
				end
			end
			i2csw_pkg::PH_ADDR_END: begin
				if (fall) begin
					ack_d   = 1'b1;
					phase_d = i2csw_pkg::PH_ADDR_ACK;
				end
			end
			i2csw_pkg::PH_DATA_END: begin
				if (fall) begin
					ack_d   = 1'b1;
					phase_d = i2csw_pkg::PH_DATA_ACK;
				end
			end
			i2csw_pkg::PH_ADDR_ACK: begin
				if (fall) begin
					ack_d = 1'b0;
					if (!shift_q[0]) begin
						phase_d      = i2csw_pkg::PH_DATA;
						bytes_done_d = 1'b0;
						bit_count_d  = '0;
						shift_d      = '0;
					end else begin
						phase_d = i2csw_pkg::PH_IDLE;
					end
				end
			end
			i2csw_pkg::PH_DATA_ACK: begin
				if (fall) begin
					ack_d = 1'b0;
					if ({1'b0, bytes_done_q} + 2'd1 >= i2csw_pkg::DATA_BYTES) begin
						phase_d = i2csw_pkg::PH_IDLE;
					end else begin
						bytes_done_d = 1'b1;
						phase_d      = i2csw_pkg::PH_DATA;
						bit_count_d  = '0;
						shift_d      = '0;
					end
				end
			end
			default: begin
				phase_d = i2csw_pkg::PH_IDLE;
				ack_d   = 1'b0;
				// start: sda falls while scl stays high
				if (prev_scl_q && sample_s1.scl && prev_sda_q && !sample_s1.sda) begin
					phase_d      = i2csw_pkg::PH_ADDR;
					bit_count_d  = '0;
					shift_d      = '0;
					bytes_done_d = 1'b0;
				end
			end
		endcase
		result.sda_pull_low = ack_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_address_q <= '0;
		end else if (cfg_valid) begin
			own_address_q <= cfg_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= i2csw_pkg::PH_IDLE;
			bit_count_q  <= '0;
			shift_q      <= '0;
			prev_scl_q   <= 1'b1;
			prev_sda_q   <= 1'b1;
			bytes_done_q <= 1'b0;
			ack_q        <= 1'b0;
		end else if (fire) begin
			phase_q      <= phase_d;
			bit_count_q  <= bit_count_d;
			shift_q      <= shift_d;
			prev_scl_q   <= sample_s1.scl;
			prev_sda_q   <= sample_s1.sda;
			bytes_done_q <= bytes_done_d;
			ack_q        <= ack_d;
		end
	end

	`ASSERT_ALWAYS(a_ack_phase, clk, arst_n, !ack_q || phase_q == i2csw_pkg::PH_ADDR_ACK || phase_q == i2csw_pkg::PH_DATA_ACK, "ack driven outside an acknowledge clock")
	`ASSERT_ALWAYS(a_cnt_range, clk, arst_n, bit_count_q <= i2csw_pkg::BYTE_BITS, "bit count past a byte")
	`ASSERT_NEXT(a_byte_end, clk, arst_n, fire && result.byte_valid, phase_q == i2csw_pkg::PH_DATA_END, "byte reported without moving to its ack")

endmodule

// ----- rtl/core/i2csw_out_stage.sv -----
module i2csw_out_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_s1,
	input  i2csw_pkg::result_t  result,
	output logic                advance,
	output logic                fire,
	output logic                out_valid,
	input  logic                out_ready,
	output i2csw_pkg::result_t  result_q
);

	logic valid_q;

	assign advance   = !valid_q || out_ready;
	assign fire      = valid_s1 && advance;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_q <= result;
		end
	end

endmodule

// ----- rtl/core/i2c_slave_write_receiver.sv -----
// I2C slave write receiver with 7-bit addressing. Each input beat is one sample of the SCL and
// SDA lines and yields exactly one output beat: sda_pull_low for the open-drain driver and, on
// the sample that completes a data byte, byte_valid with the byte and its number within the
// transfer. A start (SDA falling while SCL is high) opens a transfer; the address is shifted in
// MSB first on each rise of SCL and acknowledged when its upper ADDR_W bits match own_address.
// A write then takes two data bytes, each acknowledged and reported. Stop and repeated start
// are not detected mid-transfer. One sample is accepted every clock unless out_ready holds the
// output back; a result passes the input register, then the phase update into the result
// register. own_address is written through the cfg channel, which is always ready; the user
// must write it only while the block is idle, as the block itself does not enforce this.
module i2c_slave_write_receiver (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [i2csw_pkg::ADDR_W-1:0]        own_address,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                scl_level,
	input  logic                                sda_level,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                sda_pull_low,
	output logic                                byte_valid,
	output logic [i2csw_pkg::BYTE_W-1:0]        byte_value,
	output logic                                byte_number
);

	i2csw_pkg::sample_t  sample, sample_s1;
	i2csw_pkg::result_t  result, result_q;
	logic                valid_s1, advance, fire;

	assign cfg_ready  = 1'b1;
	assign sample.scl = scl_level;
	assign sample.sda = sda_level;

	i2csw_in_stage u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sample    (sample),
		.advance   (advance),
		.valid_s1  (valid_s1),
		.sample_s1 (sample_s1)
	);

	i2csw_fsm u_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_addr  (own_address),
		.fire      (fire),
		.sample_s1 (sample_s1),
		.result    (result)
	);

	i2csw_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.result    (result),
		.advance   (advance),
		.fire      (fire),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result_q  (result_q)
	);

	assign sda_pull_low = result_q.sda_pull_low;
	assign byte_valid   = result_q.byte_valid;
	assign byte_value   = result_q.byte_value;
	assign byte_number  = result_q.byte_number;

endmodule

// ----- verif/i2c_slave_write_receiver_tb.sv -----
`timescale 1ns / 100ps

module i2c_slave_write_receiver_tb;

	localparam int CYCLE_LIMIT = 400000;
	localparam int IDLE_PCT = 25;
	localparam int PHASE_SAMPLES = 120;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [i2csw_pkg::ADDR_W-1:0] own_address = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic scl_level = 1'b1;
	logic sda_level = 1'b1;
	logic out_valid;
	logic out_ready = 1'b0;
	logic sda_pull_low;
	logic byte_valid;
	logic [i2csw_pkg::BYTE_W-1:0] byte_value;
	logic byte_number;

	i2c_slave_write_receiver dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.own_address(own_address),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.scl_level(scl_level),
		.sda_level(sda_level),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sda_pull_low(sda_pull_low),
		.byte_valid(byte_valid),
		.byte_value(byte_value),
		.byte_number(byte_number)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// line samples waiting to be driven, and results owed by the block
	i2csw_pkg::sample_t line_queue[$];
	i2csw_pkg::result_t ack_and_byte_due[$];
	i2csw_pkg::sample_t next_sample;
	i2csw_pkg::result_t owed;

	// receiver state as the bus sees it
	logic [i2csw_pkg::ADDR_W-1:0] answer_addr = '0;
	i2csw_pkg::phase_t bus_phase = i2csw_pkg::PH_IDLE;
	logic [i2csw_pkg::CNT_W-1:0] bit_tally = '0;
	logic [i2csw_pkg::BYTE_W-1:0] shift_byte = '0;
	logic scl_was = 1'b1;
	logic sda_was = 1'b1;
	logic byte_slot = 1'b0;
	logic pulling_low = 1'b0;

	int cycle = 0;
	bit calm;
	int mismatches = 0;
	int results_seen = 0;
	int bytes_seen = 0;
	int acks_seen = 0;
	int phase_samples;
	int phase_writes;
	int writes_sent = 0;

	assign calm = (cycle >= 300) && (cycle < 800);

	function automatic i2csw_pkg::result_t next_pin_result(input logic scl, input logic sda);
		i2csw_pkg::result_t r;
		logic rise;
		logic fall;
		rise = !scl_was && scl;
		fall = scl_was && !scl;
		r = '0;
		case (bus_phase)
			i2csw_pkg::PH_ADDR, i2csw_pkg::PH_DATA: begin
				if (rise) begin
					shift_byte = {shift_byte[i2csw_pkg::BYTE_W-2:0], sda};
					bit_tally = bit_tally + 1'b1;
					if (bit_tally >= i2csw_pkg::BYTE_BITS) begin
						if (bus_phase == i2csw_pkg::PH_ADDR) begin
							bus_phase = (shift_byte[i2csw_pkg::BYTE_W-1:1] == answer_addr) ?
								i2csw_pkg::PH_ADDR_END : i2csw_pkg::PH_IDLE;
						end else begin
							r.byte_valid = 1'b1;
							r.byte_value = shift_byte;
							r.byte_number = byte_slot;
							bus_phase = i2csw_pkg::PH_DATA_END;
						end
					end
				end
			end
			i2csw_pkg::PH_ADDR_END, i2csw_pkg::PH_DATA_END: begin
				if (fall) begin
					pulling_low = 1'b1;
					bus_phase = (bus_phase == i2csw_pkg::PH_ADDR_END) ?
						i2csw_pkg::PH_ADDR_ACK : i2csw_pkg::PH_DATA_ACK;
				end
			end
			i2csw_pkg::PH_ADDR_ACK: begin
				if (fall) begin
					pulling_low = 1'b0;
					// write address goes on to data, read address drops back
					if (!shift_byte[0]) begin
						bus_phase = i2csw_pkg::PH_DATA;
						byte_slot = 1'b0;
						bit_tally = '0;
						shift_byte = '0;
					end else begin
						bus_phase = i2csw_pkg::PH_IDLE;
					end
				end
			end
			i2csw_pkg::PH_DATA_ACK: begin
				if (fall) begin
					pulling_low = 1'b0;
					if ({1'b0, byte_slot} + 2'd1 >= i2csw_pkg::DATA_BYTES) begin
						bus_phase = i2csw_pkg::PH_IDLE;
					end else begin
						byte_slot = 1'b1;
						bus_phase = i2csw_pkg::PH_DATA;
						bit_tally = '0;
						shift_byte = '0;
					end
				end
			end
			default: begin
				bus_phase = i2csw_pkg::PH_IDLE;
				pulling_low = 1'b0;
				if (scl_was && scl && sda_was && !sda) begin
					bus_phase = i2csw_pkg::PH_ADDR;
					bit_tally = '0;
					shift_byte = '0;
					byte_slot = 1'b0;
				end
			end
		endcase
		scl_was = scl;
		sda_was = sda;
		r.sda_pull_low = pulling_low;
		return r;
	endfunction

	// sample driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			scl_level <= 1'b1;
			sda_level <= 1'b1;
		end else begin
			if (in_valid && in_ready)
				ack_and_byte_due.push_back(next_pin_result(scl_level, sda_level));
			if (!in_valid || in_ready) begin
				if (line_queue.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
					next_sample = line_queue.pop_front();
					scl_level <= next_sample.scl;
					sda_level <= next_sample.sda;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (ack_and_byte_due.size() == 0) begin
					$display("%0t: result beat with nothing owed (pull %0b valid %0b byte %h)",
						$time, sda_pull_low, byte_valid, byte_value);
					mismatches++;
				end else begin
					owed = ack_and_byte_due.pop_front();
					if (owed.byte_valid)
						bytes_seen++;
					if (owed.sda_pull_low)
						acks_seen++;
					if (sda_pull_low !== owed.sda_pull_low) begin
						$display("%0t: sda_pull_low expected %0b got %0b",
							$time, owed.sda_pull_low, sda_pull_low);
						mismatches++;
					end
					if (byte_valid !== owed.byte_valid) begin
						$display("%0t: byte_valid expected %0b got %0b",
							$time, owed.byte_valid, byte_valid);
						mismatches++;
					end
					if (byte_value !== owed.byte_value) begin
						$display("%0t: byte_value expected %h got %h",
							$time, owed.byte_value, byte_value);
						mismatches++;
					end
					if (byte_number !== owed.byte_number) begin
						$display("%0t: byte_number expected %0b got %0b",
							$time, owed.byte_number, byte_number);
						mismatches++;
					end
				end
			end
			out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle == CYCLE_LIMIT) begin
			$display("%0t: timed out with %0d samples queued and %0d results owed",
				$time, line_queue.size(), ack_and_byte_due.size());
			$display("i2c_slave_write_receiver_tb failed");
			$finish;
		end
	end

	task automatic drive_line(input logic scl, input logic sda);
		i2csw_pkg::sample_t s;
		int reps;
		s.scl = scl;
		s.sda = sda;
		reps = ($urandom_range(0, 99) < 80) ? 1 : $urandom_range(2, 3);
		repeat (reps) line_queue.push_back(s);
		phase_samples += reps;
	endtask

	// one scl pulse; wiggle moves sda while scl is high (start/stop mid transfer)
	task automatic clock_bit(input logic b, input bit wiggle);
		drive_line(1'b0, b);
		drive_line(1'b1, b);
		if (wiggle) begin
			drive_line(1'b1, !b);
			drive_line(1'b1, b);
		end
	endtask

	task automatic clock_byte(input logic [i2csw_pkg::BYTE_W-1:0] v, input int wiggle_pct);
		for (int i = i2csw_pkg::BYTE_W - 1; i >= 0; i--)
			clock_bit(v[i], $urandom_range(0, 99) < wiggle_pct);
	endtask

	function automatic logic [i2csw_pkg::BYTE_W-1:0] data_pattern();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 15)
			return 8'h00;
		if (pick < 30)
			return 8'hFF;
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic transfer(input logic [i2csw_pkg::ADDR_W-1:0] addr, input logic rd,
			input int nbytes, input int wiggle_pct);
		drive_line(1'b1, 1'b1);
		drive_line(1'b1, 1'b0);
		clock_byte({addr, rd}, 0);
		clock_bit(addr != answer_addr, 1'b0);
		for (int k = 0; k < nbytes; k++) begin
			clock_byte(data_pattern(), wiggle_pct);
			clock_bit(rd ? 1'($urandom_range(0, 1)) : 1'b0, 1'b0);
		end
		if (!rd && nbytes == 2 && addr == answer_addr)
			writes_sent++;
		drive_line(1'b0, 1'b0);
		drive_line(1'b1, 1'b0);
		drive_line(1'b1, 1'b1);
	endtask

	// looked at on the falling edge so that the driver's updates have settled
	task automatic drain();
		while (line_queue.size() != 0 || in_valid || ack_and_byte_due.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		logic [i2csw_pkg::ADDR_W-1:0] addr_plan[5];
		logic [i2csw_pkg::ADDR_W-1:0] other;
		int pick;
		addr_plan[0] = 7'h00;
		addr_plan[1] = 7'h7F;
		addr_plan[2] = 7'h2A;
		addr_plan[3] = 7'h55;
		addr_plan[4] = 7'($urandom_range(1, 126));

		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		for (int p = 0; p < 5; p++) begin
			repeat (4) @(posedge clk);
			cfg_valid <= 1'b1;
			own_address <= addr_plan[p];
			do @(posedge clk); while (!cfg_ready);
			cfg_valid <= 1'b0;
			answer_addr = addr_plan[p];

			phase_samples = 0;
			phase_writes = writes_sent;
			if (p == 0) begin
				// sda falling with scl low is no start; then an all-ones address
				drive_line(1'b1, 1'b1);
				drive_line(1'b0, 1'b1);
				drive_line(1'b0, 1'b0);
				drive_line(1'b0, 1'b1);
				transfer(7'h7F, 1'b1, 0, 0);
			end
			while (phase_samples < PHASE_SAMPLES || writes_sent - phase_writes < 2) begin
				pick = $urandom_range(0, 99);
				if (pick < 45) begin
					transfer(answer_addr, 1'b0, 2, ($urandom_range(0, 99) < 30) ? 15 : 0);
				end else if (pick < 55) begin
					transfer(answer_addr, 1'b1, 1, 0);
				end else if (pick < 70) begin
					if ($urandom_range(0, 1))
						other = answer_addr ^ (7'd1 << $urandom_range(0,
							i2csw_pkg::ADDR_W - 1));
					else
						do other = 7'($urandom_range(0, 127)); while (other == answer_addr);
					transfer(other, 1'($urandom_range(0, 1)), $urandom_range(0, 1), 0);
				end else if (pick < 85) begin
					// cut-off transfer
					drive_line(1'b1, 1'b1);
					drive_line(1'b1, 1'b0);
					clock_byte({answer_addr, 1'b0}, 0);
					repeat ($urandom_range(0, 14)) clock_bit(1'($urandom_range(0, 1)), 1'b0);
					if ($urandom_range(0, 1)) begin
						drive_line(1'b0, 1'b0);
						drive_line(1'b1, 1'b0);
						drive_line(1'b1, 1'b1);
					end
				end else begin
					repeat ($urandom_range(4, 30))
						drive_line(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				end
			end

			// clock ones until the receiver is back in idle before the next address
			drain();
			while (bus_phase != i2csw_pkg::PH_IDLE) begin
				clock_bit(1'b1, 1'b0);
				drain();
			end
		end

		drain();
		repeat (8) @(posedge clk);
		$display("%0d result beats checked across 5 own addresses, %0d complete writes sent",
			results_seen, writes_sent);
		$display("%0d data bytes reported, %0d beats with sda pulled low", bytes_seen, acks_seen);
		if (mismatches == 0 && ack_and_byte_due.size() == 0) begin
			$display("i2c_slave_write_receiver_tb passed");
		end else begin
			$display("i2c_slave_write_receiver_tb failed");
		end
		$finish;
	end

endmodule
